>>> rtl/rgbdc_pkg.sv
// Package for the RGB duty command decoder.
// Holds character codes, channel indexes and the colour cycling order type.
// No dependencies.
package rgbdc_pkg;

   // character codes seen on the serial line
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_D_UP   = 8'h44;
   localparam logic [7:0] CHAR_D_LO   = 8'h64;
   localparam logic [7:0] CHAR_R_UP   = 8'h52;
   localparam logic [7:0] CHAR_R_LO   = 8'h72;
   localparam logic [7:0] CHAR_G_UP   = 8'h47;
   localparam logic [7:0] CHAR_G_LO   = 8'h67;
   localparam logic [7:0] CHAR_B_UP   = 8'h42;
   localparam logic [7:0] CHAR_B_LO   = 8'h62;

   localparam int DUTY_W   = 16;
   localparam int NUM_CH   = 3;
   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;

   // byte position inside a three-byte command
   localparam logic [1:0] POS_LETTER = 2'd0;
   localparam logic [1:0] POS_TENS   = 2'd1;

   // colour lit by the next tick in cycling mode
   typedef enum logic [1:0] {
      COLOUR_RED   = 2'd0,
      COLOUR_GREEN = 2'd1,
      COLOUR_BLUE  = 2'd2
   } colour_type;

   // whitespace as the C library sees it: space, tab through carriage return
   function automatic logic is_blank(input logic [7:0] c);
      is_blank = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

endpackage

>>> rtl/rgbdc_atoi.sv
// Two-character decimal reader with leading blank and sign, wrapped to 16 bits.
// Depends on rgbdc_pkg for character codes and class functions.
module rgbdc_atoi (
   input  logic [7:0]                   tens_char,
   input  logic [7:0]                   units_char,
   output logic [rgbdc_pkg::DUTY_W-1:0] value
);
   import rgbdc_pkg::*;

   logic [3:0] tens_digit;
   logic [3:0] units_digit;
   logic [6:0] tens_times_ten;
   logic [6:0] magnitude;
   logic       negative;

   assign tens_digit     = tens_char[3:0];
   assign units_digit    = units_char[3:0];
   assign tens_times_ten = {tens_digit, 3'b000} + {2'b00, tens_digit, 1'b0};

   // pick the magnitude by what the first character is
   always_comb begin
      magnitude = '0;
      negative  = 1'b0;
      priority if (is_blank(tens_char)) begin
         // blank then a lone digit; blank then sign leaves no digits
         if (is_digit(units_char)) magnitude = {3'b000, units_digit};
      end else if (tens_char == CHAR_PLUS || tens_char == CHAR_MINUS) begin
         negative = (tens_char == CHAR_MINUS);
         if (is_digit(units_char)) magnitude = {3'b000, units_digit};
      end else if (is_digit(tens_char)) begin
         if (is_digit(units_char)) magnitude = tens_times_ten + {3'b000, units_digit};
         else                      magnitude = {3'b000, tens_digit};
      end else begin
         magnitude = '0;
      end
   end

   // negate in 16 bits for a minus sign
   assign value = negative ? (DUTY_W'(0) - {{(DUTY_W-7){1'b0}}, magnitude})
                           : {{(DUTY_W-7){1'b0}}, magnitude};

endmodule

>>> rtl/rgb_duty_command_decoder.sv
// RGB duty command decoder: parses serial command bytes and cycling ticks.
// Uses rgbdc_pkg and the number reader rgbdc_atoi.
//
// Input channel (req_): one beat is a received byte (req_action 0) or a
// cycling tick (req_action 1). Carriage return and line feed are dropped;
// other bytes form three-byte commands: letter, then two number characters.
// R/G/B (either case) load that channel's duty and set its LED bit to show
// whether the duty is nonzero; D/d flips cycling mode; other letters do nothing.
// Output channel (rsp_): one beat per input beat carrying the three duties,
// the LED bits, the cycling mode and a flag for a completed command.
// The state update and the result register load at the accepting edge, so
// the result is valid in the next cycle.
// Throughput is one beat per cycle, set by the single result register: a
// new beat is taken whenever that register is empty or being emptied.
// While the receiver stalls with a result waiting, req_stall is raised and
// the result holds. Reset clears all duties, LEDs, cycling mode, the colour
// order (red first) and the byte position, and empties the result register.
module rgb_duty_command_decoder (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_action,
   input  logic [7:0]                   req_rx_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [rgbdc_pkg::DUTY_W-1:0] rsp_duty_red,
   output logic [rgbdc_pkg::DUTY_W-1:0] rsp_duty_green,
   output logic [rgbdc_pkg::DUTY_W-1:0] rsp_duty_blue,
   output logic [2:0]                   rsp_led_bits,
   output logic                         rsp_cycle_mode,
   output logic                         rsp_command_done
);
   import rgbdc_pkg::*;

   // command state
   logic [1:0]        byte_count_ff, byte_count_in;
   logic [7:0]        letter_ff, letter_in;
   logic [7:0]        tens_ff, tens_in;
   logic [DUTY_W-1:0] duty_ff [NUM_CH];
   logic [DUTY_W-1:0] duty_in [NUM_CH];
   logic [2:0]        led_ff, led_in;
   logic              cycle_ff, cycle_in;
   colour_type        colour_ff, colour_in;
   logic              done_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0] rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic [2:0]        rsp_led_ff;
   logic              rsp_cycle_ff, rsp_done_ff;

   logic              accept;
   logic [DUTY_W-1:0] number;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   rgbdc_atoi u_atoi (
      .tens_char  (tens_ff),
      .units_char (req_rx_byte),
      .value      (number)
   );

   // decode one beat into the next command state
   always_comb begin
      byte_count_in = byte_count_ff;
      letter_in     = letter_ff;
      tens_in       = tens_ff;
      duty_in       = duty_ff;
      led_in        = led_ff;
      cycle_in      = cycle_ff;
      colour_in     = colour_ff;
      done_in       = 1'b0;
      if (req_action) begin
         if (cycle_ff) begin
            unique case (colour_ff)
               COLOUR_RED: begin
                  led_in    = 3'b001;
                  colour_in = COLOUR_GREEN;
               end
               COLOUR_GREEN: begin
                  led_in    = 3'b010;
                  colour_in = COLOUR_BLUE;
               end
               COLOUR_BLUE: begin
                  led_in    = 3'b100;
                  colour_in = COLOUR_RED;
               end
               default: colour_in = COLOUR_RED;
            endcase
         end
      end else if (req_rx_byte != CHAR_LF && req_rx_byte != CHAR_CR) begin
         priority if (byte_count_ff == POS_LETTER) begin
            letter_in     = req_rx_byte;
            byte_count_in = POS_TENS;
         end else if (byte_count_ff == POS_TENS) begin
            tens_in       = req_rx_byte;
            byte_count_in = byte_count_ff + 2'd1;
         end else begin
            byte_count_in = POS_LETTER;
            done_in       = 1'b1;
            unique case (letter_ff)
               CHAR_D_UP, CHAR_D_LO: cycle_in = !cycle_ff;
               CHAR_R_UP, CHAR_R_LO: begin
                  duty_in[CH_RED] = number;
                  led_in[CH_RED]  = (number != '0);
               end
               CHAR_G_UP, CHAR_G_LO: begin
                  duty_in[CH_GREEN] = number;
                  led_in[CH_GREEN]  = (number != '0);
               end
               CHAR_B_UP, CHAR_B_LO: begin
                  duty_in[CH_BLUE] = number;
                  led_in[CH_BLUE]  = (number != '0);
               end
               default: ;
            endcase
         end
      end
   end

   // advance state on an accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= POS_LETTER;
         letter_ff     <= '0;
         tens_ff       <= '0;
         for (int i = 0; i < NUM_CH; i++) duty_ff[i] <= '0;
         led_ff        <= '0;
         cycle_ff      <= 1'b0;
         colour_ff     <= COLOUR_RED;
      end else if (accept) begin
         byte_count_ff <= byte_count_in;
         letter_ff     <= letter_in;
         tens_ff       <= tens_in;
         duty_ff       <= duty_in;
         led_ff        <= led_in;
         cycle_ff      <= cycle_in;
         colour_ff     <= colour_in;
      end
   end

   // fill on accept, drain when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept)                        rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   // load the result beat
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_red_ff   <= duty_in[CH_RED];
         rsp_green_ff <= duty_in[CH_GREEN];
         rsp_blue_ff  <= duty_in[CH_BLUE];
         rsp_led_ff   <= led_in;
         rsp_cycle_ff <= cycle_in;
         rsp_done_ff  <= done_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_duty_red     = rsp_red_ff;
   assign rsp_duty_green   = rsp_green_ff;
   assign rsp_duty_blue    = rsp_blue_ff;
   assign rsp_led_bits     = rsp_led_ff;
   assign rsp_cycle_mode   = rsp_cycle_ff;
   assign rsp_command_done = rsp_done_ff;

endmodule

>>> rtl/rgbdc_checker.sv
// Port-level checks for the RGB duty command decoder, bound to the top level.
// Depends on rgbdc_pkg for the duty width and line end codes.
module rgbdc_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         req_action,
   input logic [7:0]                   req_rx_byte,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [rgbdc_pkg::DUTY_W-1:0] rsp_duty_red,
   input logic [rgbdc_pkg::DUTY_W-1:0] rsp_duty_green,
   input logic [rgbdc_pkg::DUTY_W-1:0] rsp_duty_blue,
   input logic [2:0]                   rsp_led_bits,
   input logic                         rsp_cycle_mode,
   input logic                         rsp_command_done
);
   import rgbdc_pkg::*;

   // a waiting result stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // a waiting result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_duty_red) && $stable(rsp_duty_green)
         && $stable(rsp_duty_blue) && $stable(rsp_led_bits)
         && $stable(rsp_cycle_mode) && $stable(rsp_command_done))
      else $error("result payload changed while stalled");

   // every accepted beat shows a result in the cycle after it is accepted
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted beat gave no result");

   // a tick or a line end never completes a command
   a_no_done: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall
         && (req_action || req_rx_byte == CHAR_CR || req_rx_byte == CHAR_LF)
         |=> !rsp_command_done)
      else $error("tick or line end reported a completed command");

   // an empty result register never holds off the sender
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with no result waiting");

endmodule

bind rgb_duty_command_decoder rgbdc_checker u_rgbdc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_action       (req_action),
   .req_rx_byte      (req_rx_byte),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_duty_red     (rsp_duty_red),
   .rsp_duty_green   (rsp_duty_green),
   .rsp_duty_blue    (rsp_duty_blue),
   .rsp_led_bits     (rsp_led_bits),
   .rsp_cycle_mode   (rsp_cycle_mode),
   .rsp_command_done (rsp_command_done)
);
